@@ hw/rtl/bm3_pkg.sv @@
// Package for the 3x3 binary morphology block.
// Holds the sizes, the register map, and the transaction and status structs.
// It has no dependencies.
package bm3_pkg;

    localparam int MAX_LINE = 1024;
    localparam int COL_W    = $clog2(MAX_LINE);
    localparam int LEN_W    = $clog2(MAX_LINE + 1);
    localparam int ROW_W    = 16;
    localparam int PIX_W    = 8;
    localparam int CFG_LEN_W = 11;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_LEN   = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    localparam logic                 MODE_ERODE  = 1'b0;
    localparam logic                 MODE_DILATE = 1'b1;
    localparam logic [CFG_LEN_W-1:0] LEN_RESET   = CFG_LEN_W'(1024);
    localparam logic [ROW_W-1:0]     COUNT_RESET = ROW_W'(1024);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] above2;
    } entry_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             emit;
        logic             last;
    } pos_t;

endpackage

@@ hw/rtl/binary_morphology_3x3.sv @@
// Top level of the 3x3 binary erosion and dilation block.
// Depends on bm3_pkg, bm3_regs, bm3_pos, bm3_line_mem and bm3_window.
//
// Pixels of a padded image enter in raster order on the pix channel, one
// transaction per pixel with a frame_start flag on the first pixel of a frame.
// Each interior position yields one transaction on the res channel holding the
// AND (erosion) or OR (dilation) of its nine neighbors, with last set on the
// final interior result of the frame. Border pixels yield no result.
// The block takes one pixel per clock cycle while pix_stall is low. An
// accepted pixel has its line store entry read at acceptance, and its result
// is loaded into the output register when it leaves the second stage. The
// throughput is set by the single read-modify-write of the line store entry
// of each column, with forwarding when consecutive pixels hit the same entry.
// When the receiver stalls, the result waits in the output register; pixels
// that produce no result keep flowing, and the pix channel stalls only when
// a pending result cannot move on. Reset clears the position counters, the
// window and the pipeline; the line store contents stay undefined, and the
// registers return to erosion mode with 1024 by 1024 pixels per frame.
module binary_morphology_3x3
    import bm3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  pix_t              pix_data,
    output logic              res_valid,
    input  logic              res_stall,
    output res_t              res_data
);

    logic             mode;
    logic [LEN_W-1:0] width;
    logic [ROW_W-1:0] height;
    pos_t             pos;
    logic             pix_acc;
    logic             take;
    logic             s1_leave;
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             fwd_reg;
    entry_t           fwd_entry_reg;
    entry_t           rd_data;
    entry_t           s1_entry;
    entry_t           wr_data;

    bm3_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode),
        .width   (width),
        .height  (height)
    );

    bm3_pos u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (pix_acc),
        .frame_start (pix_data.frame_start),
        .width       (width),
        .height      (height),
        .pos         (pos)
    );

    assign pix_stall = s1_valid_reg && !take;
    assign pix_acc   = pix_valid && !pix_stall;
    assign s1_leave  = s1_valid_reg && take;

    assign s1_entry       = fwd_reg ? fwd_entry_reg : rd_data;
    assign wr_data.above  = s1_px_reg;
    assign wr_data.above2 = s1_entry.above;

    bm3_line_mem u_mem (
        .clk     (clk),
        .rd_en   (pix_acc),
        .rd_addr (pos.col),
        .rd_data (rd_data),
        .wr_en   (s1_leave),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (pix_acc)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_leave && (s1_col_reg == pos.col);
            end
            else if (s1_leave)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_px_reg     <= pix_data.pixel;
            s1_col_reg    <= pos.col;
            s1_emit_reg   <= pos.emit;
            s1_last_reg   <= pos.last;
            fwd_entry_reg <= wr_data;
        end
    end

    bm3_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .consume   (s1_leave),
        .emit      (s1_emit_reg),
        .last      (s1_last_reg),
        .top       (s1_entry.above2),
        .mid       (s1_entry.above),
        .bot       (s1_px_reg),
        .take      (take),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |=> s1_valid_reg)
        else $error("Accepted pixel did not reach the second stage.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !pix_stall)
        else $error("Input stalled with an empty second stage.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_acc && s1_leave && (s1_col_reg == pos.col)) |=> fwd_reg)
        else $error("Same-entry write and read were not forwarded.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !$past(res_valid)) |-> $past(s1_valid_reg && s1_emit_reg))
        else $error("Result transaction appeared without an emitting pixel.");

endmodule

@@ hw/rtl/bm3_regs.sv @@
// Configuration registers of the morphology block behind an APB-style port.
// Provides the operation mode and the clamped row length and row count.
// Depends on bm3_pkg.
module bm3_regs
    import bm3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic              mode,
    output logic [LEN_W-1:0]  width,
    output logic [ROW_W-1:0]  height
);

    logic                 mode_reg;
    logic [CFG_LEN_W-1:0] len_reg;
    logic [ROW_W-1:0]     count_reg;
    logic                 wr_en;
    logic [1:0]           index;
    int unsigned          width_val;

    assign pready = 1'b1;
    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ERODE;
            len_reg   <= LEN_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_MODE:  mode_reg  <= pwdata[0];
                REG_LEN:   len_reg   <= pwdata[CFG_LEN_W-1:0];
                REG_COUNT: count_reg <= pwdata[ROW_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_MODE:  prdata = DATA_W'(mode_reg);
            REG_LEN:   prdata = DATA_W'(len_reg);
            REG_COUNT: prdata = DATA_W'(count_reg);
            default:   prdata = '0;
        endcase
    end

    always_comb
    begin
        width_val = 32'(len_reg);
        if (width_val < 3)
        begin
            width_val = 3;
        end
        else if (width_val > MAX_LINE)
        begin
            width_val = MAX_LINE;
        end
    end

    assign mode   = mode_reg;
    assign width  = LEN_W'(width_val);
    assign height = (count_reg < ROW_W'(3)) ? ROW_W'(3) : count_reg;

endmodule

@@ hw/rtl/bm3_pos.sv @@
// Column and row tracking for the incoming pixel stream.
// Gives the position of the current pixel and whether it completes a window.
// Depends on bm3_pkg.
module bm3_pos
    import bm3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             frame_start,
    input  logic [LEN_W-1:0] width,
    input  logic [ROW_W-1:0] height,
    output pos_t             pos
);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [LEN_W-1:0] c0;
    logic [COL_W-1:0] c1;
    logic [ROW_W-1:0] r0;
    logic [ROW_W:0]   r1;
    logic [ROW_W-1:0] r2;
    logic [LEN_W-1:0] cn;
    logic [ROW_W:0]   rn;

    always_comb
    begin
        c0 = frame_start ? '0 : LEN_W'(col_reg);
        r0 = frame_start ? '0 : row_reg;
        if (c0 >= width)
        begin
            c1 = '0;
            r1 = {1'b0, r0} + 1'b1;
        end
        else
        begin
            c1 = c0[COL_W-1:0];
            r1 = {1'b0, r0};
        end
        r2 = (r1 >= {1'b0, height}) ? '0 : r1[ROW_W-1:0];

        cn = LEN_W'(c1) + 1'b1;
        rn = {1'b0, r2} + 1'b1;
        if (cn >= width)
        begin
            col_next = '0;
            row_next = (rn >= {1'b0, height}) ? '0 : rn[ROW_W-1:0];
        end
        else
        begin
            col_next = cn[COL_W-1:0];
            row_next = r2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.col  = c1;
    assign pos.emit = (r2 >= ROW_W'(2)) && (c1 >= COL_W'(2));
    assign pos.last = (r2 == height - 1'b1) && (LEN_W'(c1) == width - 1'b1);

endmodule

@@ hw/rtl/bm3_line_mem.sv @@
// Line store memory holding the two previous rows, one entry per column.
// One write port and one read port with a registered read.
// Depends on bm3_pkg.
module bm3_line_mem
    import bm3_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output entry_t           rd_data,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  entry_t           wr_data
);

    entry_t mem [MAX_LINE];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bm3_window.sv @@
// Sliding 3x3 window, the AND/OR reduction and the result output register.
// Shifts in one column per consumed pixel and registers the result transaction.
// Depends on bm3_pkg.
module bm3_window
    import bm3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mode,
    input  logic             consume,
    input  logic             emit,
    input  logic             last,
    input  logic [PIX_W-1:0] top,
    input  logic [PIX_W-1:0] mid,
    input  logic [PIX_W-1:0] bot,
    output logic             take,
    output logic             res_valid,
    input  logic             res_stall,
    output res_t             res_data
);

    logic [PIX_W-1:0] col0_reg [3];
    logic [PIX_W-1:0] col1_reg [3];
    logic [PIX_W-1:0] and_val;
    logic [PIX_W-1:0] or_val;
    logic             res_valid_reg;
    logic             res_valid_next;
    res_t             res_data_reg;
    logic             load;

    always_comb
    begin
        and_val = top & mid & bot;
        or_val  = top | mid | bot;
        for (int k = 0; k < 3; k++)
        begin
            and_val = and_val & col0_reg[k] & col1_reg[k];
            or_val  = or_val | col0_reg[k] | col1_reg[k];
        end
    end

    assign take = !emit || !res_valid_reg || !res_stall;
    assign load = consume && emit;

    always_comb
    begin
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_stall)
        begin
            res_valid_next = res_valid_reg;
        end
        else
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                col0_reg[k] <= '0;
                col1_reg[k] <= '0;
            end
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (consume)
            begin
                col0_reg    <= col1_reg;
                col1_reg[0] <= top;
                col1_reg[1] <= mid;
                col1_reg[2] <= bot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_data_reg.value <= (mode == MODE_DILATE) ? or_val : and_val;
            res_data_reg.last  <= last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

@@ dv/tb.sv @@
// Testbench for binary_morphology_3x3: streams padded frames through the block and checks
// each eroded or dilated result against a cycle-free predictor kept in this file.
// Depends on bm3_pkg and the binary_morphology_3x3 RTL.
module tb;
    import bm3_pkg::*;

    typedef enum int {PIX_NOISE, PIX_DENSE, PIX_SPARSE, PIX_BINARY} pix_style_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              pix_valid = 1'b0;
    logic              pix_stall;
    pix_t              pix_data = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    res_t              res_data;

    int pix_idle = 20;
    int res_idle = 20;
    int hold_left = 0;
    int fail_count = 0;
    int pixels_sent = 0;

    logic                 morph_mode;
    logic [CFG_LEN_W-1:0] line_len_reg;
    logic [ROW_W-1:0]     line_cnt_reg;
    logic [PIX_W-1:0]     line_above [MAX_LINE];
    logic [PIX_W-1:0]     line_above2 [MAX_LINE];
    logic [PIX_W-1:0]     nbhd [9];
    int unsigned          col_pos;
    int unsigned          row_pos;
    res_t                 morph_results_q [$];
    res_t                 front_res;

    binary_morphology_3x3 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        morph_mode   = MODE_ERODE;
        line_len_reg = LEN_RESET;
        line_cnt_reg = COUNT_RESET;
        col_pos      = 0;
        row_pos      = 0;
        for (int k = 0; k < 9; k++)
        begin
            nbhd[k] = '0;
        end
    end

    function automatic int unsigned row_width();
        if (line_len_reg < 3)
        begin
            return 3;
        end
        if (line_len_reg > MAX_LINE)
        begin
            return MAX_LINE;
        end
        return line_len_reg;
    endfunction

    function automatic int unsigned frame_rows();
        return (line_cnt_reg < 3) ? 3 : line_cnt_reg;
    endfunction

    function automatic int frame_pixels();
        return row_width() * frame_rows();
    endfunction

    function automatic void morph_pixel(input pix_t p);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic [PIX_W-1:0] acc;
        res_t res;
        w = row_width();
        h = frame_rows();
        if (p.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
        begin
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        for (int k = 0; k < 3; k++)
        begin
            nbhd[k*3]   = nbhd[k*3+1];
            nbhd[k*3+1] = nbhd[k*3+2];
        end
        nbhd[2] = line_above2[c];
        nbhd[5] = line_above[c];
        nbhd[8] = p.pixel;
        line_above2[c] = line_above[c];
        line_above[c]  = p.pixel;
        if (r >= 2 && c >= 2)
        begin
            acc = nbhd[0];
            for (int k = 1; k < 9; k++)
            begin
                acc = (morph_mode == MODE_DILATE) ? (acc | nbhd[k]) : (acc & nbhd[k]);
            end
            res.value = acc;
            res.last  = (r == h - 1) && (c == w - 1);
            morph_results_q.push_back(res);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endfunction

    // Results are checked before the accepted pixel of the same edge is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (morph_results_q.size() == 0)
                begin
                    $error("unexpected transaction: value %h last %b",
                           res_data.value, res_data.last);
                    fail_count++;
                end
                else
                begin
                    front_res = morph_results_q.pop_front();
                    if (res_data.value !== front_res.value)
                    begin
                        $error("value: expected %h, actual %h", front_res.value, res_data.value);
                        fail_count++;
                    end
                    if (res_data.last !== front_res.last)
                    begin
                        $error("last: expected %b, actual %b", front_res.last, res_data.last);
                        fail_count++;
                    end
                end
            end
            if (pix_valid && !pix_stall)
            begin
                morph_pixel(pix_data);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < res_idle);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] stored;
        case (idx)
            REG_MODE: stored = DATA_W'(val[0]);
            REG_LEN:  stored = DATA_W'(val[CFG_LEN_W-1:0]);
            default:  stored = DATA_W'(val[ROW_W-1:0]);
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_MODE: morph_mode   = stored[0];
            REG_LEN:  line_len_reg = stored[CFG_LEN_W-1:0];
            default:  line_cnt_reg = stored[ROW_W-1:0];
        endcase
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== stored)
        begin
            $error("prdata: expected %h, actual %h", stored, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
        int gap;
        gap = 0;
        while ($urandom_range(99) < pix_idle)
        begin
            gap++;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= '{pixel: px, frame_start: fs};
        do @(posedge clk); while (pix_stall);
        pixels_sent++;
    endtask

    task automatic settle_block();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (morph_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input pix_style_t style);
        case (style)
            PIX_DENSE:  return ($urandom_range(9) < 3) ? ~(8'h01 << $urandom_range(7)) : 8'hFF;
            PIX_SPARSE: return ($urandom_range(9) < 3) ? (8'h01 << $urandom_range(7)) : 8'h00;
            PIX_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
            default:    return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // A frame_start inside the frame at restart_at begins a new frame mid stream.
    task automatic send_frame(input int n, input bit fs_first, input pix_style_t style,
                              input int restart_at);
        for (int i = 0; i < n; i++)
        begin
            send_pixel(pick_pixel(style), (i == 0 && fs_first) || i == restart_at);
        end
    endtask

    task automatic test_directed();
        write_reg(REG_MODE, MODE_ERODE);
        write_reg(REG_LEN, 3);
        write_reg(REG_COUNT, 0);
        for (int i = 0; i < 9; i++)
        begin
            send_pixel(8'hFF, i == 0);
        end
        settle_block();
        write_reg(REG_MODE, MODE_DILATE);
        write_reg(REG_LEN, 2);
        write_reg(REG_COUNT, 2);
        for (int i = 0; i < 9; i++)
        begin
            send_pixel((i == 4) ? 8'h80 : 8'h00, i == 0);
        end
        for (int i = 0; i < 9; i++)
        begin
            send_pixel((i == 0) ? 8'h01 : 8'h00, 1'b0);
        end
        settle_block();
    endtask

    task automatic test_frame_start();
        write_reg(REG_MODE, MODE_ERODE);
        write_reg(REG_LEN, 5);
        write_reg(REG_COUNT, 4);
        send_frame(7, 1'b1, PIX_DENSE, -1);
        send_frame(20, 1'b1, PIX_DENSE, -1);
        send_frame(20, 1'b1, PIX_BINARY, -1);
        settle_block();
    endtask

    task automatic test_mid_frame_registers();
        write_reg(REG_MODE, MODE_DILATE);
        write_reg(REG_LEN, 8);
        write_reg(REG_COUNT, 6);
        send_frame(27, 1'b1, PIX_SPARSE, -1);
        settle_block();
        write_reg(REG_LEN, 3);
        write_reg(REG_MODE, MODE_ERODE);
        send_frame(10, 1'b0, PIX_DENSE, -1);
        settle_block();
        write_reg(REG_COUNT, 0);
        send_frame(22, 1'b0, PIX_DENSE, -1);
        settle_block();
        write_reg(REG_COUNT, 7);
        send_frame(20, 1'b0, PIX_DENSE, -1);
        settle_block();
    endtask

    task automatic test_line_count_extremes();
        write_reg(REG_MODE, MODE_DILATE);
        write_reg(REG_LEN, 4);
        write_reg(REG_COUNT, 65535);
        send_frame(48, 1'b1, PIX_SPARSE, -1);
        settle_block();
        write_reg(REG_COUNT, 5);
        send_frame(40, 1'b0, PIX_SPARSE, -1);
        settle_block();
    endtask

    task automatic test_backpressure();
        write_reg(REG_MODE, MODE_DILATE);
        write_reg(REG_LEN, 6);
        write_reg(REG_COUNT, 6);
        pix_idle  = 0;
        hold_left = 250;
        send_frame(108, 1'b1, PIX_NOISE, -1);
        settle_block();
        send_frame(36, 1'b0, PIX_SPARSE, -1);
        settle_block();
        pix_idle = 20;
    endtask

    task automatic test_wide_lines();
        pix_idle = 0;
        res_idle = 0;
        write_reg(REG_MODE, MODE_ERODE);
        write_reg(REG_LEN, 160);
        write_reg(REG_COUNT, 3);
        send_frame(3 * 160, 1'b1, PIX_DENSE, -1);
        settle_block();
        pix_idle = 20;
        res_idle = 20;
        write_reg(REG_LEN, 2047);
        write_reg(REG_MODE, MODE_DILATE);
        send_frame(20, 1'b1, PIX_SPARSE, -1);
        settle_block();
    endtask

    // Mostly whole frames with random content; some are cut short or restarted,
    // and every frame after such a break opens with frame_start.
    task automatic test_random();
        int start;
        int phase;
        int k;
        int n;
        int frames;
        bit need_start;
        bit quiet;
        pix_style_t style;
        start = pixels_sent;
        phase = 0;
        need_start = 1'b1;
        while (pixels_sent - start < 1060)
        begin
            settle_block();
            quiet = (phase % 5 == 2);
            pix_idle = quiet ? 0 : 20;
            res_idle = quiet ? 0 : 20;
            if (phase == 0 || $urandom_range(3) != 0)
            begin
                write_reg(REG_MODE, $urandom_range(1));
            end
            if (phase == 0 || $urandom_range(2) != 0)
            begin
                k = $urandom_range(99);
                write_reg(REG_LEN, (k < 8) ? $urandom_range(2) :
                                   (k < 14) ? $urandom_range(17, 40) : $urandom_range(3, 12));
            end
            if (phase == 0 || $urandom_range(2) != 0)
            begin
                k = $urandom_range(99);
                write_reg(REG_COUNT, (k < 8) ? $urandom_range(2) : $urandom_range(3, 9));
            end
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames; f++)
            begin
                style = pix_style_t'($urandom_range(3));
                n = frame_pixels();
                k = $urandom_range(99);
                if (k < 10)
                begin
                    send_frame($urandom_range(1, n - 1), need_start, style, -1);
                    need_start = 1'b1;
                end
                else if (k < 18)
                begin
                    send_frame(n, need_start, style, $urandom_range(1, n - 1));
                    need_start = 1'b1;
                end
                else
                begin
                    send_frame(n, need_start || $urandom_range(1), style, -1);
                    need_start = 1'b0;
                end
                if ($urandom_range(9) == 0)
                begin
                    settle_block();
                end
            end
            phase++;
        end
        settle_block();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_frame_start();
        test_mid_frame_registers();
        test_line_count_extremes();
        test_backpressure();
        test_wide_lines();
        test_random();
        settle_block();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && morph_results_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ binary_morphology_3x3.f @@
hw/rtl/bm3_pkg.sv
hw/rtl/bm3_regs.sv
hw/rtl/bm3_pos.sv
hw/rtl/bm3_line_mem.sv
hw/rtl/bm3_window.sv
hw/rtl/binary_morphology_3x3.sv
dv/tb.sv
